FILE: rtl/fll_pkg.sv
// shared token kinds and constants for the lexer
`timescale 1ns / 1ps

package fll_pkg;

    // token kinds on the result channel
    typedef enum logic [4:0] {
        KIND_EOL     = 5'd0,
        KIND_COMMENT = 5'd1,
        KIND_INTEGER = 5'd2,
        KIND_WORD    = 5'd3,
        KIND_ADD     = 5'd4,
        KIND_SUB     = 5'd5,
        KIND_EQUALS  = 5'd6,
        KIND_DEF     = 5'd7,
        KIND_END     = 5'd8,
        KIND_IF      = 5'd9,
        KIND_ELSE    = 5'd10,
        KIND_ENDIF   = 5'd11,
        KIND_DUP     = 5'd12,
        KIND_DROP    = 5'd13,
        KIND_SWAP    = 5'd14,
        KIND_OVER    = 5'd15,
        KIND_DOT     = 5'd16,
        KIND_EMIT    = 5'd17,
        KIND_CR      = 5'd18,
        KIND_LPAREN  = 5'd19,
        KIND_RPAREN  = 5'd20
    } kind_t;

    localparam int DEFAULT_WORD_CAPACITY = 32;
    localparam int MAX_RESULTS           = 5;
    localparam int CHUNK_CHARS           = 8;

    // saturation limit of the decimal accumulator and its tenth
    localparam logic [62:0] SAT_VALUE = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] SAT_TENTH = SAT_VALUE / 10;

endpackage

FILE: rtl/forth_like_lexer.sv
// byte-stream lexer for a small stack language
`timescale 1ns / 1ps

// Usage:
// Source bytes enter on the in_valid / in_ready channel (ch, final_req), one
// beat per byte. Tokens leave on the out_valid / out_ready channel (kind,
// number, text_chunk, chunk_bytes, last), one token per beat; last marks the
// final token caused by one input byte.
// Word bytes produce no token and are taken at one per cycle while in_ready is
// high. A delimiter byte gives its first token in the cycle after its beat, from
// the output register. A flushed word of n characters that is not a number or
// keyword gives ceil(n/8) text chunks (at most five tokens per byte in all), the
// first from the shadow register and the rest one per cycle from the word memory
// while the receiver takes them; in_ready stays low until the last token of the
// byte is in the output register. Throughput is one byte per cycle without a
// stall; a number or keyword before a delimiter token also holds in_ready low.
// When the receiver stalls, the output register holds its token and in_ready
// drops, since a new byte is taken only when the output register is free or
// drains in the same cycle.
// Reset empties the output register, drops any queued tokens and clears the
// word length, digit accumulator and number phase; the word memory holds
// undefined data and needs no clearing pass.

module forth_like_lexer #(
    parameter int WORD_CAPACITY = fll_pkg::DEFAULT_WORD_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        final_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  kind,
    output logic signed [31:0] number,
    output logic [63:0] text_chunk,
    output logic [3:0]  chunk_bytes,
    output logic        last
);

    localparam int LEN_W = $clog2(WORD_CAPACITY);
    localparam int ROWS  = (WORD_CAPACITY + fll_pkg::CHUNK_CHARS - 1) / fll_pkg::CHUNK_CHARS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(WORD_CAPACITY - 1);

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VTAB   = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_DIGIT = 3'b010,
        PH_OTHER = 3'b100
    } phase_t;

    typedef struct packed {
        logic            is_delim;
        logic            has_token;
        fll_pkg::kind_t  dkind;
    } delim_t;

    typedef struct packed {
        logic            hit;
        fll_pkg::kind_t  kind;
    } kw_t;

    typedef struct packed {
        fll_pkg::kind_t  kind;
        logic [31:0]     number;
        logic [63:0]     chunk;
        logic [3:0]      bytes;
        logic            last;
    } result_t;

    // byte enables for the first n characters of a chunk
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            m[b*8 +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // keyword lookup on the first five characters, first character in low byte
    function automatic kw_t keyword_lookup(input logic [2:0] n, input logic [63:0] w);
        logic [39:0] rev;
        kw_t         r;
        rev    = {w[7:0], w[15:8], w[23:16], w[31:24], w[39:32]};
        r.hit  = 1'b0;
        r.kind = fll_pkg::KIND_WORD;
        unique case (n)
            3'd2:
            begin
                if (rev[39:24] == "if")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_IF;
                end
                else if (rev[39:24] == "cr")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_CR;
                end
            end
            3'd3:
            begin
                if (rev[39:16] == "dup")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_DUP;
                end
                else if (rev[39:16] == "def")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_DEF;
                end
                else if (rev[39:16] == "end")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_END;
                end
            end
            3'd4:
            begin
                if (rev[39:8] == "else")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_ELSE;
                end
                else if (rev[39:8] == "drop")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_DROP;
                end
                else if (rev[39:8] == "swap")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_SWAP;
                end
                else if (rev[39:8] == "over")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_OVER;
                end
                else if (rev[39:8] == "emit")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_EMIT;
                end
            end
            3'd5:
            begin
                if (rev == "endif")
                begin
                    r.hit = 1'b1; r.kind = fll_pkg::KIND_ENDIF;
                end
            end
            default:
            begin
                r.hit = 1'b0;
            end
        endcase
        return r;
    endfunction

    // word state
    logic [LEN_W-1:0] len_reg;
    logic [62:0]      digit_reg;
    phase_t           phase_reg;
    logic [63:0]      shadow_reg;

    // word memory, one 8-character row per entry
    logic [63:0]      word_mem [ROWS];
    logic [63:0]      rd_data_reg;

    // queued tokens behind the output register
    logic [2:0]       seq_rem_reg, seq_rem_next;
    logic             seq_delim_reg, seq_delim_next;
    fll_pkg::kind_t   seq_dkind_reg, seq_dkind_next;
    logic [ROW_W-1:0] seq_row_reg, seq_row_next;
    logic [LEN_W-1:0] seq_len_reg, seq_len_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             busy, out_free, accept, wr_en, len_small;
    delim_t           dl;
    logic             is_blank, is_digit;
    logic [3:0]       digit;
    logic [62:0]      limit, times10;
    logic [62:0]      digit_next;
    phase_t           phase_next;
    kw_t              kw;
    logic [LEN_W:0]   nch;
    logic             many;
    logic [2:0]       first_rem;
    logic             first_delim, produce;
    logic [3:0]       first_cnt;
    result_t          first;
    logic [LEN_W-1:0] seq_diff;
    logic [3:0]       seq_cnt;
    logic [ROW_W-1:0] wr_row;
    logic [2:0]       wr_lane;

    // handshake
    assign busy     = (seq_rem_reg != 3'd0) || seq_delim_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !busy && out_free;
    assign accept   = in_valid && in_ready;

    // delimiter decode
    always_comb
    begin
        dl.is_delim  = 1'b1;
        dl.has_token = 1'b1;
        dl.dkind     = fll_pkg::KIND_EOL;
        unique case (ch)
            CH_NL:     dl.dkind = fll_pkg::KIND_EOL;
            CH_BSLASH: dl.dkind = fll_pkg::KIND_COMMENT;
            CH_DOT:    dl.dkind = fll_pkg::KIND_DOT;
            CH_PLUS:   dl.dkind = fll_pkg::KIND_ADD;
            CH_MINUS:  dl.dkind = fll_pkg::KIND_SUB;
            CH_LPAREN: dl.dkind = fll_pkg::KIND_LPAREN;
            CH_RPAREN: dl.dkind = fll_pkg::KIND_RPAREN;
            CH_EQUALS: dl.dkind = fll_pkg::KIND_EQUALS;
            CH_SPACE:  dl.has_token = 1'b0;
            default:
            begin
                dl.is_delim  = 1'b0;
                dl.has_token = 1'b0;
            end
        endcase
    end

    // number recognition and saturating accumulate
    assign is_blank = (ch == CH_TAB) || (ch == CH_VTAB) || (ch == CH_FF) || (ch == CH_CR);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign limit    = (digit > 4'd7) ? (fll_pkg::SAT_TENTH - 63'd1) : fll_pkg::SAT_TENTH;
    assign times10  = (digit_reg << 3) + (digit_reg << 1);

    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        if ((phase_reg == PH_LEAD) && is_blank)
        begin
            phase_next = PH_LEAD;
        end
        else if (((phase_reg == PH_LEAD) || (phase_reg == PH_DIGIT)) && is_digit)
        begin
            phase_next = PH_DIGIT;
            digit_next = (digit_reg > limit) ? fll_pkg::SAT_VALUE
                                             : times10 + 63'(digit);
        end
        else
        begin
            phase_next = PH_OTHER;
        end
    end

    // first token of a delimiter beat
    assign len_small = ({1'b0, len_reg} < (LEN_W+1)'(8));
    assign kw        = keyword_lookup(len_small ? len_reg[2:0] : 3'd0, shadow_reg);
    assign nch       = ({1'b0, len_reg} + (LEN_W+1)'(7)) >> 3;
    assign many      = (nch >= (LEN_W+1)'(fll_pkg::MAX_RESULTS));
    assign first_cnt = len_small ? {1'b0, len_reg[2:0]} : 4'd8;

    always_comb
    begin
        first        = '0;
        first.kind   = fll_pkg::KIND_EOL;
        first_rem    = 3'd0;
        first_delim  = 1'b0;
        produce      = 1'b0;
        if (len_reg != '0)
        begin
            produce = 1'b1;
            if (phase_reg == PH_DIGIT)
            begin
                first.kind   = fll_pkg::KIND_INTEGER;
                first.number = digit_reg[31:0];
                first.last   = !dl.has_token;
                first_delim  = dl.has_token;
            end
            else if (kw.hit)
            begin
                first.kind  = kw.kind;
                first.last  = !dl.has_token;
                first_delim = dl.has_token;
            end
            else
            begin
                first.kind  = fll_pkg::KIND_WORD;
                first.chunk = shadow_reg & byte_mask(first_cnt);
                first.bytes = first_cnt;
                first_rem   = many ? 3'(fll_pkg::MAX_RESULTS - 1) : 3'(nch - (LEN_W+1)'(1));
                first_delim = dl.has_token && !many;
                first.last  = (first_rem == 3'd0) && !first_delim;
            end
        end
        else if (dl.has_token)
        begin
            produce    = 1'b1;
            first.kind = dl.dkind;
            first.last = 1'b1;
        end
    end

    // character count of the queued chunk
    assign seq_diff = seq_len_reg - LEN_W'({seq_row_reg, 3'b000});
    assign seq_cnt  = ({1'b0, seq_diff} >= (LEN_W+1)'(8)) ? 4'd8 : {1'b0, seq_diff[2:0]};

    // output register and token queue
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        seq_rem_next   = seq_rem_reg;
        seq_delim_next = seq_delim_reg;
        seq_dkind_next = seq_dkind_reg;
        seq_row_next   = seq_row_reg;
        seq_len_next   = seq_len_reg;
        if (busy && out_free)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (seq_rem_reg != 3'd0)
            begin
                out_next.kind  = fll_pkg::KIND_WORD;
                out_next.chunk = rd_data_reg & byte_mask(seq_cnt);
                out_next.bytes = seq_cnt;
                out_next.last  = (seq_rem_reg == 3'd1) && !seq_delim_reg;
                seq_rem_next   = seq_rem_reg - 3'd1;
                seq_row_next   = seq_row_reg + ROW_W'(1);
            end
            else
            begin
                out_next.kind  = seq_dkind_reg;
                out_next.last  = 1'b1;
                seq_delim_next = 1'b0;
            end
        end
        else if (accept && dl.is_delim && produce)
        begin
            out_valid_next = 1'b1;
            out_next       = first;
            seq_rem_next   = first_rem;
            seq_delim_next = first_delim;
            seq_dkind_next = dl.dkind;
            seq_row_next   = ROW_W'(1);
            seq_len_next   = len_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_rem_reg   <= 3'd0;
            seq_delim_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            seq_rem_reg   <= seq_rem_next;
            seq_delim_reg <= seq_delim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        seq_dkind_reg <= seq_dkind_next;
        seq_row_reg   <= seq_row_next;
        seq_len_reg   <= seq_len_next;
    end

    // word length, phase and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            digit_reg <= '0;
            phase_reg <= PH_LEAD;
        end
        else if (accept)
        begin
            if (dl.is_delim || final_req || (len_reg == LEN_LAST))
            begin
                len_reg   <= '0;
                digit_reg <= '0;
                phase_reg <= PH_LEAD;
            end
            else
            begin
                len_reg   <= len_reg + LEN_W'(1);
                digit_reg <= digit_next;
                phase_reg <= phase_next;
            end
        end
    end

    // word character writes
    assign wr_en   = accept && !dl.is_delim;
    assign wr_row  = ROW_W'(len_reg >> 3);
    assign wr_lane = len_reg[2:0];

    always_ff @(posedge clk)
    begin
        if (wr_en && len_small)
        begin
            shadow_reg[{wr_lane, 3'b000} +: 8] <= ch;
        end
    end

    // word memory: one byte-lane write, one registered row read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_row][{wr_lane, 3'b000} +: 8] <= ch;
        end
        rd_data_reg <= word_mem[seq_row_next];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign number      = out_reg.number;
    assign text_chunk  = out_reg.chunk;
    assign chunk_bytes = out_reg.bytes;
    assign last        = out_reg.last;

endmodule

FILE: rtl/fll_checker.sv
// port-level assertions for the lexer and their bind
`timescale 1ns / 1ps

module fll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  ch,
    input logic        final_req,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  kind,
    input logic signed [31:0] number,
    input logic [63:0] text_chunk,
    input logic [3:0]  chunk_bytes,
    input logic        last
);

    // a stalled token beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(number)
            && $stable(text_chunk) && $stable(chunk_bytes) && $stable(last))
        else $error("stalled token changed");

    // no byte taken while the output register is blocked
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("byte accepted while output stalled");

    // only word tokens carry text
    a_text_only_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != fll_pkg::KIND_WORD) |-> (text_chunk == 64'd0) && (chunk_bytes == 4'd0))
        else $error("text on a non-word token");

    // word chunks hold one to eight characters
    a_word_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == fll_pkg::KIND_WORD) |-> (chunk_bytes != 4'd0) && (chunk_bytes <= 4'd8))
        else $error("bad chunk character count");

    // only integer tokens carry a value
    a_number_only_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != fll_pkg::KIND_INTEGER) |-> (number == 32'sd0))
        else $error("value on a non-integer token");

endmodule

bind forth_like_lexer fll_checker u_fll_checker (.*);
